FILE: design/sgr_pkg.sv
// shared types and constants for the sgr pen attribute decoder
// no dependencies; imported by sgr_pen_step, sgr_pen_attribute_decoder, sgr_pen_checker and the testbench
package sgr_pkg;

	typedef enum logic [1:0] {
		KIND_DEFAULT = 2'd0,
		KIND_INDEXED = 2'd1,
		KIND_RGB     = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_SUBSEL = 3'd1,
		PH_INDEX  = 3'd2,
		PH_RED    = 3'd3,
		PH_GREEN  = 3'd4,
		PH_BLUE   = 3'd5
	} phase_t;

	typedef struct packed {
		kind_t       fg_kind;
		logic [23:0] fg_value;
		kind_t       bg_kind;
		logic [23:0] bg_value;
		logic [7:0]  attr;
	} pen_t;

	typedef struct packed {
		phase_t     phase;
		logic       target_bg;
		logic [7:0] red;
		logic [7:0] green;
	} ext_t;

	typedef struct packed {
		logic signed [16:0] value;
		logic               last;
		logic               empty;
	} item_t;

	localparam pen_t PEN_RESET = '{
		fg_kind:  KIND_DEFAULT,
		fg_value: 24'd0,
		bg_kind:  KIND_DEFAULT,
		bg_value: 24'd0,
		attr:     8'd0
	};

	localparam ext_t EXT_RESET = '{
		phase:     PH_IDLE,
		target_bg: 1'b0,
		red:       8'd0,
		green:     8'd0
	};

	// sgr codes
	localparam logic [6:0] SGR_RESET      = 7'd0;
	localparam logic [6:0] SGR_SET_FIRST  = 7'd1;
	localparam logic [6:0] SGR_SET_LAST   = 7'd9;
	localparam logic [6:0] SGR_CLR_BOLD   = 7'd21;
	localparam logic [6:0] SGR_CLR_FAINT  = 7'd22;
	localparam logic [6:0] SGR_CLR_ITALIC = 7'd23;
	localparam logic [6:0] SGR_CLR_UNDER  = 7'd24;
	localparam logic [6:0] SGR_CLR_BLINK  = 7'd25;
	localparam logic [6:0] SGR_CLR_REV    = 7'd27;
	localparam logic [6:0] SGR_CLR_INVIS  = 7'd28;
	localparam logic [6:0] SGR_CLR_STRIKE = 7'd29;
	localparam logic [6:0] SGR_FG_BASE    = 7'd30;
	localparam logic [6:0] SGR_FG_EXT     = 7'd38;
	localparam logic [6:0] SGR_FG_DEFAULT = 7'd39;
	localparam logic [6:0] SGR_BG_BASE    = 7'd40;
	localparam logic [6:0] SGR_BG_EXT     = 7'd48;
	localparam logic [6:0] SGR_BG_DEFAULT = 7'd49;
	localparam logic [6:0] SGR_FG_BRIGHT  = 7'd90;
	localparam logic [6:0] SGR_BG_BRIGHT  = 7'd100;
	localparam logic [6:0] SGR_COLOR_SPAN = 7'd7;
	localparam logic [7:0] BRIGHT_OFFSET  = 8'd8;

	// sub-selectors after an extended colour code
	localparam logic signed [16:0] SUB_INDEXED = 17'sd5;
	localparam logic signed [16:0] SUB_RGB     = 17'sd2;

endpackage

FILE: design/sgr_pen_step.sv
// next pen and extended colour state for one sgr parameter
// depends on sgr_pkg
module sgr_pen_step import sgr_pkg::*; (
	input  pen_t  pen,
	input  ext_t  ext,
	input  item_t item,
	output pen_t  nxt_pen,
	output ext_t  nxt_ext
);

	logic        ord_en;
	logic        apply_en;
	kind_t       apply_kind;
	logic [23:0] apply_value;
	logic [7:0]  comp;
	logic [15:0] code_full;
	logic [6:0]  code;
	logic        code_small;

	// clamp to 0..255
	always_comb begin
		if (item.value[16]) begin
			comp = 8'd0;
		end else if (|item.value[15:8]) begin
			comp = 8'hff;
		end else begin
			comp = item.value[7:0];
		end
	end

	assign code_full  = item.value[16] ? 16'd0 : item.value[15:0];
	assign code_small = (code_full[15:7] == 9'd0);
	assign code       = code_full[6:0];

	always_comb begin
		nxt_pen     = pen;
		nxt_ext     = ext;
		ord_en      = 1'b0;
		apply_en    = 1'b0;
		apply_kind  = KIND_DEFAULT;
		apply_value = 24'd0;

		if (item.empty) begin
			nxt_pen       = PEN_RESET;
			nxt_ext.phase = PH_IDLE;
		end else begin
			case (ext.phase)
				PH_SUBSEL: begin
					if (item.value == SUB_INDEXED) begin
						nxt_ext.phase = PH_INDEX;
						apply_en      = item.last;
						apply_kind    = KIND_INDEXED;
					end else if (item.value == SUB_RGB) begin
						nxt_ext.phase = PH_RED;
						apply_en      = item.last;
						apply_kind    = KIND_RGB;
					end else begin
						nxt_ext.phase = PH_IDLE;
						ord_en        = 1'b1;
					end
				end
				PH_INDEX: begin
					apply_en      = 1'b1;
					apply_kind    = KIND_INDEXED;
					apply_value   = {16'd0, comp};
					nxt_ext.phase = PH_IDLE;
				end
				PH_RED: begin
					nxt_ext.red   = comp;
					nxt_ext.phase = PH_GREEN;
					apply_en      = item.last;
					apply_kind    = KIND_RGB;
					apply_value   = {comp, 16'd0};
				end
				PH_GREEN: begin
					nxt_ext.green = comp;
					nxt_ext.phase = PH_BLUE;
					apply_en      = item.last;
					apply_kind    = KIND_RGB;
					apply_value   = {ext.red, comp, 8'd0};
				end
				PH_BLUE: begin
					apply_en      = 1'b1;
					apply_kind    = KIND_RGB;
					apply_value   = {ext.red, ext.green, comp};
					nxt_ext.phase = PH_IDLE;
				end
				default: begin
					nxt_ext.phase = PH_IDLE;
					ord_en        = 1'b1;
				end
			endcase

			// finished extended colour goes to the selected side
			if (apply_en) begin
				if (ext.target_bg) begin
					nxt_pen.bg_kind  = apply_kind;
					nxt_pen.bg_value = apply_value;
				end else begin
					nxt_pen.fg_kind  = apply_kind;
					nxt_pen.fg_value = apply_value;
				end
			end

			// ordinary code decode; large codes mean nothing
			if (ord_en && code_small) begin
				if (code == SGR_RESET) begin
					nxt_pen = PEN_RESET;
				end else if (code >= SGR_SET_FIRST && code <= SGR_SET_LAST) begin
					case (code[3:0])
						4'd1:    nxt_pen.attr = pen.attr | 8'h01;
						4'd2:    nxt_pen.attr = pen.attr | 8'h02;
						4'd3:    nxt_pen.attr = pen.attr | 8'h04;
						4'd4:    nxt_pen.attr = pen.attr | 8'h08;
						4'd5:    nxt_pen.attr = pen.attr | 8'h10;
						4'd6:    nxt_pen.attr = pen.attr | 8'h10;
						4'd7:    nxt_pen.attr = pen.attr | 8'h20;
						4'd8:    nxt_pen.attr = pen.attr | 8'h40;
						4'd9:    nxt_pen.attr = pen.attr | 8'h80;
						default: nxt_pen.attr = pen.attr;
					endcase
				end else if (code == SGR_CLR_BOLD || code == SGR_CLR_FAINT) begin
					nxt_pen.attr = pen.attr & ~8'h03;
				end else if (code == SGR_CLR_ITALIC) begin
					nxt_pen.attr = pen.attr & ~8'h04;
				end else if (code == SGR_CLR_UNDER) begin
					nxt_pen.attr = pen.attr & ~8'h08;
				end else if (code == SGR_CLR_BLINK) begin
					nxt_pen.attr = pen.attr & ~8'h10;
				end else if (code == SGR_CLR_REV) begin
					nxt_pen.attr = pen.attr & ~8'h20;
				end else if (code == SGR_CLR_INVIS) begin
					nxt_pen.attr = pen.attr & ~8'h40;
				end else if (code == SGR_CLR_STRIKE) begin
					nxt_pen.attr = pen.attr & ~8'h80;
				end else if (code >= SGR_FG_BASE && code <= SGR_FG_BASE + SGR_COLOR_SPAN) begin
					nxt_pen.fg_kind  = KIND_INDEXED;
					nxt_pen.fg_value = {16'd0, 1'b0, code - SGR_FG_BASE};
				end else if (code >= SGR_BG_BASE && code <= SGR_BG_BASE + SGR_COLOR_SPAN) begin
					nxt_pen.bg_kind  = KIND_INDEXED;
					nxt_pen.bg_value = {16'd0, 1'b0, code - SGR_BG_BASE};
				end else if (code >= SGR_FG_BRIGHT
					&& code <= SGR_FG_BRIGHT + SGR_COLOR_SPAN) begin
					nxt_pen.fg_kind  = KIND_INDEXED;
					nxt_pen.fg_value = {16'd0, {1'b0, code - SGR_FG_BRIGHT} + BRIGHT_OFFSET};
				end else if (code >= SGR_BG_BRIGHT
					&& code <= SGR_BG_BRIGHT + SGR_COLOR_SPAN) begin
					nxt_pen.bg_kind  = KIND_INDEXED;
					nxt_pen.bg_value = {16'd0, {1'b0, code - SGR_BG_BRIGHT} + BRIGHT_OFFSET};
				end else if (code == SGR_FG_DEFAULT) begin
					nxt_pen.fg_kind  = KIND_DEFAULT;
					nxt_pen.fg_value = 24'd0;
				end else if (code == SGR_BG_DEFAULT) begin
					nxt_pen.bg_kind  = KIND_DEFAULT;
					nxt_pen.bg_value = 24'd0;
				end else if (code == SGR_FG_EXT || code == SGR_BG_EXT) begin
					nxt_ext.target_bg = (code == SGR_BG_EXT);
					nxt_ext.phase     = PH_SUBSEL;
				end
			end

			// a parameter marked last always closes any extended colour
			if (item.last) begin
				nxt_ext.phase = PH_IDLE;
			end
		end
	end

endmodule

FILE: design/sgr_pen_attribute_decoder.sv
// top level of the sgr pen attribute decoder: input register, pen register
// depends on sgr_pkg and sgr_pen_step
// usage:
//   one request on the input channel carries one sgr parameter (param_value,
//   -1 when omitted), last_param marking the final parameter, and
//   empty_sequence for a bare sequence that resets the pen
//   every input request yields exactly one output request: the pen
//   (fg/bg kind and value, attr_bits) after that parameter
// timing:
//   out_valid rises after input accept once the parameter has passed the input
//   register and the pen update logic into the pen register, which waits out a stall
//   throughput is one parameter per cycle while the receiver takes pens; the limit
//   is the pen update loop (pen register -> decode -> pen register)
// stall:
//   the pen register doubles as the output register and only advances when
//   the output slot is empty or being taken; while the receiver stalls the
//   input register holds one parameter and in_ready drops after that
// reset:
//   arst_n clears the pen to default colours with no attributes, drops any
//   pending extended colour, and empties both registers
module sgr_pen_attribute_decoder import sgr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [16:0] param_value,
	input  logic               last_param,
	input  logic               empty_sequence,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         fg_kind,
	output logic [23:0]        fg_value,
	output logic [1:0]         bg_kind,
	output logic [23:0]        bg_value,
	output logic [7:0]         attr_bits
);

	item_t item_s1;
	logic  valid_s1;
	pen_t  pen_q;
	ext_t  ext_q;
	logic  out_valid_q;
	pen_t  nxt_pen;
	ext_t  nxt_ext;
	logic  advance;

	// the parameter in the input register moves on when the output slot frees
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register: payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.value <= param_value;
			item_s1.last  <= last_param;
			item_s1.empty <= empty_sequence;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	sgr_pen_step u_step (
		.pen     (pen_q),
		.ext     (ext_q),
		.item    (item_s1),
		.nxt_pen (nxt_pen),
		.nxt_ext (nxt_ext)
	);

	// pen and extended colour state; the pen is also the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q <= PEN_RESET;
			ext_q <= EXT_RESET;
		end else if (advance) begin
			pen_q <= nxt_pen;
			ext_q <= nxt_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign fg_kind   = pen_q.fg_kind;
	assign fg_value  = pen_q.fg_value;
	assign bg_kind   = pen_q.bg_kind;
	assign bg_value  = pen_q.bg_value;
	assign attr_bits = pen_q.attr;

endmodule

FILE: verif/sgr_pen_checker.sv
// pen predictor and result scoreboard for the sgr pen attribute decoder
// depends on sgr_pkg; instantiated beside the block by tb_sgr_pen_attribute_decoder
module sgr_pen_checker import sgr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [16:0] param_value,
	input  logic               last_param,
	input  logic               empty_sequence,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         fg_kind,
	input  logic [23:0]        fg_value,
	input  logic [1:0]         bg_kind,
	input  logic [23:0]        bg_value,
	input  logic [7:0]         attr_bits,
	output int                 pending,
	output int                 mismatch_count,
	output int                 pens_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// attribute bit positions, bold at bit 0
	localparam int BIT_BOLD    = 0;
	localparam int BIT_FAINT   = 1;
	localparam int BIT_ITALIC  = 2;
	localparam int BIT_UNDER   = 3;
	localparam int BIT_BLINK   = 4;
	localparam int BIT_REVERSE = 5;
	localparam int BIT_INVIS   = 6;
	localparam int BIT_STRIKE  = 7;

	pen_t pen_q;
	ext_t ext_q;
	pen_t pens_due[$];
	pen_t want;
	int   errors;
	int   checked;

	function automatic logic [7:0] clamp_byte(input logic signed [16:0] v);
		if (v < 0)
			return 8'd0;
		if (v > 17'sd255)
			return 8'd255;
		return v[7:0];
	endfunction

	task automatic apply_ext(input kind_t k, input logic [23:0] val);
		if (ext_q.target_bg) begin
			pen_q.bg_kind  = k;
			pen_q.bg_value = val;
		end else begin
			pen_q.fg_kind  = k;
			pen_q.fg_value = val;
		end
	endtask

	// one ordinary sgr code; omitted and negative count as reset
	task automatic apply_code(input logic signed [16:0] raw);
		int code;
		int offs;
		code = (raw < 0) ? 0 : int'(raw);
		if (code == SGR_RESET) begin
			pen_q = PEN_RESET;
		end else if (code >= SGR_SET_FIRST && code <= SGR_SET_LAST) begin
			// rapid blink shares the blink bit, so codes above it shift down one
			offs = code - SGR_SET_FIRST;
			pen_q.attr[(offs > BIT_BLINK) ? offs - 1 : offs] = 1'b1;
		end else if (code >= SGR_FG_BASE && code <= SGR_FG_BASE + SGR_COLOR_SPAN) begin
			pen_q.fg_kind  = KIND_INDEXED;
			pen_q.fg_value = 24'(code - SGR_FG_BASE);
		end else if (code >= SGR_BG_BASE && code <= SGR_BG_BASE + SGR_COLOR_SPAN) begin
			pen_q.bg_kind  = KIND_INDEXED;
			pen_q.bg_value = 24'(code - SGR_BG_BASE);
		end else if (code >= SGR_FG_BRIGHT && code <= SGR_FG_BRIGHT + SGR_COLOR_SPAN) begin
			pen_q.fg_kind  = KIND_INDEXED;
			pen_q.fg_value = 24'(code - SGR_FG_BRIGHT + BRIGHT_OFFSET);
		end else if (code >= SGR_BG_BRIGHT && code <= SGR_BG_BRIGHT + SGR_COLOR_SPAN) begin
			pen_q.bg_kind  = KIND_INDEXED;
			pen_q.bg_value = 24'(code - SGR_BG_BRIGHT + BRIGHT_OFFSET);
		end else begin
			case (code)
				SGR_CLR_BOLD, SGR_CLR_FAINT: begin
					pen_q.attr[BIT_BOLD]  = 1'b0;
					pen_q.attr[BIT_FAINT] = 1'b0;
				end
				SGR_CLR_ITALIC: pen_q.attr[BIT_ITALIC]  = 1'b0;
				SGR_CLR_UNDER:  pen_q.attr[BIT_UNDER]   = 1'b0;
				SGR_CLR_BLINK:  pen_q.attr[BIT_BLINK]   = 1'b0;
				SGR_CLR_REV:    pen_q.attr[BIT_REVERSE] = 1'b0;
				SGR_CLR_INVIS:  pen_q.attr[BIT_INVIS]   = 1'b0;
				SGR_CLR_STRIKE: pen_q.attr[BIT_STRIKE]  = 1'b0;
				SGR_FG_DEFAULT: begin
					pen_q.fg_kind  = KIND_DEFAULT;
					pen_q.fg_value = 24'd0;
				end
				SGR_BG_DEFAULT: begin
					pen_q.bg_kind  = KIND_DEFAULT;
					pen_q.bg_value = 24'd0;
				end
				SGR_FG_EXT, SGR_BG_EXT: begin
					ext_q.target_bg = (code == SGR_BG_EXT);
					ext_q.phase     = PH_SUBSEL;
				end
				default: ;
			endcase
		end
	endtask

	// pen after one accepted parameter
	task automatic advance_pen(input logic signed [16:0] v, input logic l, input logic e);
		if (e) begin
			pen_q       = PEN_RESET;
			ext_q.phase = PH_IDLE;
		end else begin
			case (ext_q.phase)
				PH_SUBSEL: begin
					if (v == SUB_INDEXED) begin
						ext_q.phase = PH_INDEX;
						if (l)
							apply_ext(KIND_INDEXED, 24'd0);
					end else if (v == SUB_RGB) begin
						ext_q.phase = PH_RED;
						if (l)
							apply_ext(KIND_RGB, 24'd0);
					end else begin
						// unknown sub-selector falls back to an ordinary code
						ext_q.phase = PH_IDLE;
						apply_code(v);
					end
				end
				PH_INDEX: begin
					apply_ext(KIND_INDEXED, {16'd0, clamp_byte(v)});
					ext_q.phase = PH_IDLE;
				end
				PH_RED: begin
					ext_q.red   = clamp_byte(v);
					ext_q.phase = PH_GREEN;
					if (l)
						apply_ext(KIND_RGB, {ext_q.red, 16'd0});
				end
				PH_GREEN: begin
					ext_q.green = clamp_byte(v);
					ext_q.phase = PH_BLUE;
					if (l)
						apply_ext(KIND_RGB, {ext_q.red, ext_q.green, 8'd0});
				end
				PH_BLUE: begin
					apply_ext(KIND_RGB, {ext_q.red, ext_q.green, clamp_byte(v)});
					ext_q.phase = PH_IDLE;
				end
				default: begin
					ext_q.phase = PH_IDLE;
					apply_code(v);
				end
			endcase
			if (l)
				ext_q.phase = PH_IDLE;
		end
	endtask

	task automatic compare_field(input string field, input logic [23:0] exp_v,
			input logic [23:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q = PEN_RESET;
			ext_q = EXT_RESET;
			pens_due.delete();
			errors  = 0;
			checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pens_due.size() == 0) begin
					$display("%0t ns: pen delivered with no request outstanding", $time);
					errors++;
				end else begin
					want = pens_due.pop_front();
					compare_field("fg_kind", 24'(want.fg_kind), 24'(fg_kind));
					compare_field("fg_value", want.fg_value, fg_value);
					compare_field("bg_kind", 24'(want.bg_kind), 24'(bg_kind));
					compare_field("bg_value", want.bg_value, bg_value);
					compare_field("attr_bits", 24'(want.attr), 24'(attr_bits));
					checked++;
				end
			end
			if (in_valid && in_ready) begin
				advance_pen(param_value, last_param, empty_sequence);
				pens_due.push_back(pen_q);
			end
		end
		pending        <= pens_due.size();
		mismatch_count <= errors;
		pens_checked   <= checked;
	end

endmodule

FILE: verif/tb_sgr_pen_attribute_decoder.sv
// top of the sgr pen attribute decoder testbench: clock, reset, stimulus, verdict
// depends on sgr_pkg, sgr_pen_attribute_decoder and sgr_pen_checker
module tb_sgr_pen_attribute_decoder;
	import sgr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// items per random phase, four phases of different idle/stall mix
	localparam int PHASE_ITEMS     = 330;
	localparam int IDLE_PLAN [4]   = '{0, 73, 0, 18};
	localparam int STALL_PLAN [4]  = '{0, 0, 73, 18};
	// long receiver hold-off, well beyond the two-entry buffering of the block
	localparam int HOLD_CYCLES     = 200;
	// idle margin after the last pen before the verdict
	localparam int DRAIN_CYCLES    = 8;
	localparam int WATCHDOG_CYCLES = 2000;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic signed [16:0] param_value    = '0;
	logic               last_param     = 1'b0;
	logic               empty_sequence = 1'b0;
	logic               out_valid;
	logic               out_ready      = 1'b0;
	logic [1:0]         fg_kind;
	logic [23:0]        fg_value;
	logic [1:0]         bg_kind;
	logic [23:0]        bg_value;
	logic [7:0]         attr_bits;

	int pending;
	int mismatch_count;
	int pens_checked;

	// knobs for the request generator and the ready generator
	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_asks = 0;

	int items_sent  = 0;
	int seq_count   = 0;
	int bare_count  = 0;
	int quiet_count = 0;
	int seq_buf[$];

	sgr_pen_attribute_decoder u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.param_value    (param_value),
		.last_param     (last_param),
		.empty_sequence (empty_sequence),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.fg_kind        (fg_kind),
		.fg_value       (fg_value),
		.bg_kind        (bg_kind),
		.bg_value       (bg_value),
		.attr_bits      (attr_bits)
	);

	sgr_pen_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.param_value    (param_value),
		.last_param     (last_param),
		.empty_sequence (empty_sequence),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.fg_kind        (fg_kind),
		.fg_value       (fg_value),
		.bg_kind        (bg_kind),
		.bg_value       (bg_value),
		.attr_bits      (attr_bits),
		.pending        (pending),
		.mismatch_count (mismatch_count),
		.pens_checked   (pens_checked)
	);

	// 4 ns clock
	initial begin
		forever #2 clk = ~clk;
	end

	// one parameter request: random idle gap first, then hold valid until taken
	task automatic send_param(input int v, input logic l, input logic e);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		param_value    <= 17'(v);
		last_param     <= l;
		empty_sequence <= e;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// bare sequence: value and last mark are don't-care, so randomize them
	task automatic send_bare();
		send_param($urandom_range(1) ? -1 : int'($urandom_range(65535)),
			1'($urandom_range(1)), 1'b1);
		bare_count++;
	endtask

	// sends seq_buf as one sequence; noisy mode sometimes drops the last mark
	// and sometimes slips a bare reset in the middle
	task automatic send_sequence(input bit noisy);
		int  n;
		bit  open_end;
		n        = seq_buf.size();
		open_end = noisy && ($urandom_range(19) == 0);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(99) < 3)
				send_bare();
			send_param(seq_buf[i], (i == n - 1) && !open_end, 1'b0);
		end
		seq_count++;
	endtask

	// random ordinary code, weighted across every code group plus unknowns
	function automatic int pick_code();
		case ($urandom_range(9))
			0: return SGR_RESET;
			1: return SGR_SET_FIRST + $urandom_range(SGR_SET_LAST - SGR_SET_FIRST);
			2: return SGR_CLR_BOLD + $urandom_range(SGR_CLR_STRIKE - SGR_CLR_BOLD);
			3: return $urandom_range(1) ? SGR_FG_DEFAULT
				: SGR_FG_BASE + $urandom_range(SGR_COLOR_SPAN);
			4: return $urandom_range(1) ? SGR_BG_DEFAULT
				: SGR_BG_BASE + $urandom_range(SGR_COLOR_SPAN);
			5: return SGR_FG_BRIGHT + $urandom_range(SGR_COLOR_SPAN);
			6: return SGR_BG_BRIGHT + $urandom_range(SGR_COLOR_SPAN);
			7: return -1;
			8: return $urandom_range(1)
				? $urandom_range(SGR_BG_BRIGHT + SGR_COLOR_SPAN + 1, 65535)
				: $urandom_range(SGR_SET_LAST + 1, SGR_CLR_BOLD - 1);
			default: return $urandom_range(SGR_BG_BRIGHT + SGR_COLOR_SPAN);
		endcase
	endfunction

	// colour component or index, leaning on the clamp edges
	function automatic int pick_level();
		case ($urandom_range(9))
			0: return -1;
			1: return 255;
			2: return 256;
			3: return $urandom_range(257, 65535);
			4: return 65535;
			5: return 0;
			default: return $urandom_range(255);
		endcase
	endfunction

	// mostly well-formed sequences mixing codes with 38/48 extended colours
	task automatic random_sequences(input int n);
		int stop_at;
		int r;
		int cut;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 6) begin
				send_bare();
				continue;
			end
			seq_buf.delete();
			repeat ($urandom_range(1, 4)) begin
				r = $urandom_range(99);
				if (r < 50) begin
					seq_buf.push_back(pick_code());
				end else begin
					seq_buf.push_back($urandom_range(1) ? SGR_BG_EXT : SGR_FG_EXT);
					r = $urandom_range(9);
					if (r < 4) begin
						seq_buf.push_back(SUB_INDEXED);
						seq_buf.push_back(pick_level());
					end else if (r < 8) begin
						seq_buf.push_back(SUB_RGB);
						repeat (3) seq_buf.push_back(pick_level());
					end else begin
						// broken extended colour: anything as sub-selector
						seq_buf.push_back(pick_code());
					end
				end
			end
			// cut some sequences short so extended colours end early
			if ($urandom_range(4) == 0) begin
				cut = $urandom_range(1, seq_buf.size());
				while (seq_buf.size() > cut)
					void'(seq_buf.pop_back());
			end
			send_sequence(1'b1);
		end
	endtask

	// stop offering and wait until every predicted pen has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// ready generator: random stalls per phase, plus the long hold-off on demand
	initial begin : ready_gen
		int hold_left;
		int hold_served;
		hold_left   = 0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_asks != hold_served) begin
				hold_served++;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog: too long with no request moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_count <= 0;
			else
				quiet_count <= quiet_count + 1;
			if (quiet_count >= WATCHDOG_CYCLES) begin
				$display("%0t ns: watchdog, no request moved for %0d cycles", $time, quiet_count);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bare reset with omitted value
		send_param(-1, 1'b0, 1'b1);
		bare_count++;
		// set bold, blink, invisible, strike; then clear bold/faint and strike
		seq_buf = {SGR_SET_FIRST, SGR_SET_FIRST + 4, SGR_SET_LAST - 1, SGR_SET_LAST,
			SGR_CLR_FAINT, SGR_CLR_STRIKE};
		send_sequence(1'b0);
		// indexed foreground with the largest value, clamped
		seq_buf = {SGR_FG_EXT, SUB_INDEXED, 65535};
		send_sequence(1'b0);
		// rgb background: omitted red, green just past range, blue at the top
		seq_buf = {SGR_BG_EXT, SUB_RGB, -1, 256, 255};
		send_sequence(1'b0);
		// unknown sub-selector decoded as an ordinary code (reverse)
		seq_buf = {SGR_FG_EXT, SGR_SET_FIRST + 6};
		send_sequence(1'b0);
		// sequence ends inside r;g;b, missing components become zero
		seq_buf = {SGR_BG_EXT, SUB_RGB, 200};
		send_sequence(1'b0);
		// top bright colours, an unknown code at the field maximum, then reset
		seq_buf = {SGR_FG_BRIGHT + SGR_COLOR_SPAN, SGR_BG_BRIGHT + SGR_COLOR_SPAN, 65535,
			SGR_RESET};
		send_sequence(1'b0);
		// extended colour code as the last parameter does nothing
		seq_buf = {SGR_FG_EXT};
		send_sequence(1'b0);
		wait_drained();

		// random phases, each drained before the next idle/stall mix
		for (int p = 0; p < 4; p++) begin
			idle_pct  = IDLE_PLAN[p];
			stall_pct = STALL_PLAN[p];
			if (p == 0) begin
				random_sequences(PHASE_ITEMS / 2);
				// receiver holds off while requests keep coming, filling the block
				hold_asks++;
				random_sequences(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				random_sequences(PHASE_ITEMS);
			end
			wait_drained();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d parameters in %0d sequences and %0d bare resets", items_sent,
			seq_count, bare_count);
		$display("under four idle/stall mixes with one long output hold-off; %0d pens compared",
			pens_checked);
		if (mismatch_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
